/* rtl/core/tcf_pkg.sv */
// Package: state and op codes and word types for the TCP connection state machine.
package tcf_pkg;

    localparam int STATE_W = 4;
    localparam int OP_W    = 3;

    localparam logic [STATE_W-1:0] CONN_CLOSED      = 4'd0;
    localparam logic [STATE_W-1:0] CONN_LISTEN      = 4'd1;
    localparam logic [STATE_W-1:0] CONN_SYN_SENT    = 4'd2;
    localparam logic [STATE_W-1:0] CONN_SYN_RCVD    = 4'd3;
    localparam logic [STATE_W-1:0] CONN_ESTABLISHED = 4'd4;
    localparam logic [STATE_W-1:0] CONN_FIN_WAIT_1  = 4'd5;
    localparam logic [STATE_W-1:0] CONN_FIN_WAIT_2  = 4'd6;
    localparam logic [STATE_W-1:0] CONN_CLOSE_WAIT  = 4'd7;
    localparam logic [STATE_W-1:0] CONN_CLOSING     = 4'd8;
    localparam logic [STATE_W-1:0] CONN_LAST_ACK    = 4'd9;
    localparam logic [STATE_W-1:0] CONN_TIME_WAIT   = 4'd10;

    localparam logic [OP_W-1:0] OP_ACTIVE_OPEN  = 3'd0;
    localparam logic [OP_W-1:0] OP_PASSIVE_OPEN = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND         = 3'd2;
    localparam logic [OP_W-1:0] OP_CLOSE        = 3'd3;
    localparam logic [OP_W-1:0] OP_PACKET       = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            syn_flag;
        logic            ack_flag;
        logic            fin_flag;
    } evt_t;

    typedef struct packed {
        logic [STATE_W-1:0] conn_state;
        logic               moved;
        logic               fault;
        logic               passed_time_wait;
    } result_t;

endpackage

/* rtl/core/tcp_connection_fsm.sv */
// Top level: one simplified TCP connection state machine with valid/stall channels.
//
// Usage notes:
// - Event channel (evt_valid, evt_stall, evt_word): one word per connection
//   event, an op plus the SYN/ACK/FIN flags of a packet. A word is taken at a
//   rising edge with evt_valid high and evt_stall low.
// - Result channel (res_valid, res_stall, res_word): exactly one word per
//   event: state after the event, moved, fault and passed_time_wait.
// - The result word is registered: it shows on res_valid from the output
//   register, or waits in the skid stage while the receiver stalls. Throughput:
//   one event per cycle while evt_stall is low, set by the single registered state
//   and the next-state decode in front of it.
// - The state register updates at the edge that takes the event, so the next event already sees the new state.
// - Reset (rst_n low, asynchronous): state goes to closed, both output
//   stages empty, evt_stall low.
// - When the receiver stalls, the waiting result holds in the output register
//   and one more event is taken into the skid stage; evt_stall then rises
//   and stays high until the receiver takes a word.
module tcp_connection_fsm
    import tcf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    evt_valid,
    output logic    evt_stall,
    input  evt_t    evt_word,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_word
);

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    result_t            dec_res;
    logic               take;

    assign take = evt_valid && !evt_stall;

    tcf_decode u_decode (
        .state (state_reg),
        .evt   (evt_word),
        .res   (dec_res)
    );

    // ignored and fault events leave the state as is; decode already folds that in
    assign state_next = take ? dec_res.conn_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CONN_CLOSED;
        else
            state_reg <= state_next;
    end

    tcf_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_word (dec_res),
        .full      (evt_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

/* rtl/core/tcf_decode.sv */
// Next-state decode: current connection state plus one event gives the result word.
module tcf_decode
    import tcf_pkg::*;
(
    input  logic [STATE_W-1:0] state,
    input  evt_t               evt,
    output result_t            res
);

    logic [STATE_W-1:0] nxt;
    logic               go;
    logic               bad;
    logic               passed;

    always_comb
    begin
        nxt = state;
        go  = 1'b0;
        bad = 1'b0;
        case (evt.op)
            OP_ACTIVE_OPEN:
            begin
                if (state == CONN_CLOSED)
                begin
                    go  = 1'b1;
                    nxt = CONN_SYN_SENT;
                end
            end
            OP_PASSIVE_OPEN:
            begin
                if (state == CONN_CLOSED)
                begin
                    go  = 1'b1;
                    nxt = CONN_LISTEN;
                end
            end
            OP_SEND:
            begin
                case (state)
                    CONN_LISTEN:
                    begin
                        go  = 1'b1;
                        nxt = CONN_SYN_SENT;
                    end
                    CONN_CLOSED, CONN_FIN_WAIT_1, CONN_FIN_WAIT_2, CONN_CLOSE_WAIT,
                    CONN_CLOSING, CONN_LAST_ACK, CONN_TIME_WAIT:
                        bad = 1'b1;
                    default:
                        bad = 1'b0;
                endcase
            end
            OP_CLOSE:
            begin
                case (state)
                    CONN_LISTEN, CONN_SYN_SENT:
                    begin
                        go  = 1'b1;
                        nxt = CONN_CLOSED;
                    end
                    CONN_SYN_RCVD, CONN_ESTABLISHED:
                    begin
                        go  = 1'b1;
                        nxt = CONN_FIN_WAIT_1;
                    end
                    CONN_CLOSE_WAIT:
                    begin
                        go  = 1'b1;
                        nxt = CONN_LAST_ACK;
                    end
                    default:
                        go = 1'b0;
                endcase
            end
            OP_PACKET:
            begin
                case (state)
                    CONN_LISTEN:
                    begin
                        go  = evt.syn_flag;
                        nxt = CONN_SYN_RCVD;
                    end
                    CONN_SYN_SENT:
                    begin
                        go  = evt.syn_flag;
                        nxt = evt.ack_flag ? CONN_ESTABLISHED : CONN_SYN_RCVD;
                    end
                    CONN_SYN_RCVD:
                    begin
                        go  = evt.ack_flag;
                        nxt = CONN_ESTABLISHED;
                    end
                    CONN_ESTABLISHED:
                    begin
                        go  = evt.fin_flag;
                        nxt = CONN_CLOSE_WAIT;
                    end
                    CONN_FIN_WAIT_1:
                    begin
                        go = evt.fin_flag | evt.ack_flag;
                        if (evt.fin_flag && evt.ack_flag)
                            nxt = CONN_TIME_WAIT;
                        else if (evt.fin_flag)
                            nxt = CONN_CLOSING;
                        else
                            nxt = CONN_FIN_WAIT_2;
                    end
                    CONN_FIN_WAIT_2:
                    begin
                        go  = evt.fin_flag;
                        nxt = CONN_TIME_WAIT;
                    end
                    CONN_CLOSING:
                    begin
                        go  = evt.ack_flag;
                        nxt = CONN_TIME_WAIT;
                    end
                    CONN_LAST_ACK:
                    begin
                        go  = evt.ack_flag;
                        nxt = CONN_CLOSED;
                    end
                    default:
                        go = 1'b0;
                endcase
            end
            default:
                go = 1'b0;
        endcase
    end

    // time_wait is never held: it drops straight through to closed
    assign passed = go && (nxt == CONN_TIME_WAIT);

    always_comb
    begin
        res.moved            = go;
        res.fault            = bad;
        res.passed_time_wait = passed;
        if (!go)
            res.conn_state = state;
        else if (passed)
            res.conn_state = CONN_CLOSED;
        else
            res.conn_state = nxt;
    end

endmodule

/* rtl/core/tcf_out_skid.sv */
// Result output register with a one-word skid stage behind it.
module tcf_out_skid
    import tcf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    full,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res_word
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && !res_stall;
    assign full      = skid_valid_reg;
    assign res_valid = main_valid_reg;
    assign res_word  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
                main_reg <= push_word;
            else
                skid_reg <= push_word;
        end
    end

endmodule

/* sim/tcp_connection_fsm_chk.sv */
// Checker for the TCP connection state machine: predicts each result word and compares it.
module tcp_connection_fsm_chk
    import tcf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    evt_valid,
    input  logic    evt_stall,
    input  evt_t    evt_word,
    input  logic    res_valid,
    input  logic    res_stall,
    input  result_t res_word,
    output int      mismatches,
    output int      words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [STATE_W-1:0] conn_now;
    result_t            expected_words[$];
    result_t            want;

    // Next connection state for one event. Every legal move lands on a state
    // other than the current one, so "moved" is simply nxt != st.
    function automatic result_t advance_connection(input logic [STATE_W-1:0] st,
                                                   input evt_t ev);
        logic [STATE_W-1:0] nxt;
        logic               bad;
        result_t            r;
        nxt = st;
        bad = 1'b0;
        case (ev.op)
            OP_ACTIVE_OPEN:
                if (st == CONN_CLOSED)
                    nxt = CONN_SYN_SENT;
            OP_PASSIVE_OPEN:
                if (st == CONN_CLOSED)
                    nxt = CONN_LISTEN;
            OP_SEND:
                case (st)
                    CONN_LISTEN: nxt = CONN_SYN_SENT;
                    CONN_CLOSED, CONN_FIN_WAIT_1, CONN_FIN_WAIT_2, CONN_CLOSE_WAIT,
                    CONN_CLOSING, CONN_LAST_ACK, CONN_TIME_WAIT: bad = 1'b1;
                    default: ;
                endcase
            OP_CLOSE:
                case (st)
                    CONN_LISTEN, CONN_SYN_SENT:        nxt = CONN_CLOSED;
                    CONN_SYN_RCVD, CONN_ESTABLISHED:   nxt = CONN_FIN_WAIT_1;
                    CONN_CLOSE_WAIT:                   nxt = CONN_LAST_ACK;
                    default: ;
                endcase
            OP_PACKET:
                case (st)
                    CONN_LISTEN:
                        if (ev.syn_flag)
                            nxt = CONN_SYN_RCVD;
                    CONN_SYN_SENT:
                        if (ev.syn_flag && ev.ack_flag)
                            nxt = CONN_ESTABLISHED;
                        else if (ev.syn_flag)
                            nxt = CONN_SYN_RCVD;
                    CONN_SYN_RCVD:
                        if (ev.ack_flag)
                            nxt = CONN_ESTABLISHED;
                    CONN_ESTABLISHED:
                        if (ev.fin_flag)
                            nxt = CONN_CLOSE_WAIT;
                    CONN_FIN_WAIT_1:
                        if (ev.fin_flag && ev.ack_flag)
                            nxt = CONN_TIME_WAIT;
                        else if (ev.fin_flag)
                            nxt = CONN_CLOSING;
                        else if (ev.ack_flag)
                            nxt = CONN_FIN_WAIT_2;
                    CONN_FIN_WAIT_2:
                        if (ev.fin_flag)
                            nxt = CONN_TIME_WAIT;
                    CONN_CLOSING:
                        if (ev.ack_flag)
                            nxt = CONN_TIME_WAIT;
                    CONN_LAST_ACK:
                        if (ev.ack_flag)
                            nxt = CONN_CLOSED;
                    default: ;
                endcase
            default: ;
        endcase
        r.conn_state       = st;
        r.moved            = 1'b0;
        r.fault            = bad;
        r.passed_time_wait = 1'b0;
        if (!bad && nxt != st)
        begin
            r.moved = 1'b1;
            // time_wait is never held: report it and drop to closed
            if (nxt == CONN_TIME_WAIT)
            begin
                r.passed_time_wait = 1'b1;
                nxt = CONN_CLOSED;
            end
            r.conn_state = nxt;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            conn_now      = CONN_CLOSED;
            mismatches    = 0;
            words_pending = 0;
        end
        else
        begin
            // results are registered and never leave in the cycle their event is taken, so pop first
            if (res_valid && !res_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result word:", $realtime,
                                 " state %0d moved %0b", res_word.conn_state,
                                 res_word.moved,
                                 " fault %0b tw %0b", res_word.fault,
                                 res_word.passed_time_wait);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (res_word.conn_state !== want.conn_state
                        || res_word.moved !== want.moved
                        || res_word.fault !== want.fault
                        || res_word.passed_time_wait !== want.passed_time_wait)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch:", $realtime,
                                     " expected state %0d moved %0b fault %0b tw %0b,",
                                     want.conn_state, want.moved, want.fault,
                                     want.passed_time_wait,
                                     " got state %0d moved %0b fault %0b tw %0b",
                                     res_word.conn_state, res_word.moved,
                                     res_word.fault, res_word.passed_time_wait);
                    end
                end
            end
            if (evt_valid && !evt_stall)
            begin
                want     = advance_connection(conn_now, evt_word);
                conn_now = want.conn_state;
                expected_words.push_back(want);
            end
            words_pending = expected_words.size();
        end
    end

endmodule

/* sim/tcp_connection_fsm_tb.sv */
// Testbench top for the TCP connection state machine: stimulus, receiver stalls and verdict.
module tcp_connection_fsm_tb
    import tcf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // roughly this many random event words after the directed walk
    localparam int RANDOM_WORDS = 2000;
    // worst case is far below this: ~2030 words, each at most a sender gap
    // plus a long receiver stall run
    localparam int CYCLE_LIMIT  = 400000;
    // extra cycles after the drain catch any stray result word
    localparam int TAIL_CYCLES  = 8;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    evt_valid;
    logic    evt_stall;
    evt_t    evt_word;
    logic    res_valid;
    logic    res_stall;
    result_t res_word;

    int mismatches;
    int words_pending;
    int cycles = 0;
    int burst_left = 1;
    int words_sent = 0;

    tcp_connection_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt_word  (evt_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    tcp_connection_fsm_chk chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt_valid     (evt_valid),
        .evt_stall     (evt_stall),
        .evt_word      (evt_word),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res_word      (res_word),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tcp_connection_fsm_tb failed");
            $finish;
        end
    end

    // Receiver: segments of random length, each in one mode -- never stall,
    // coin-flip stall, or long stall runs with a single open cycle between.
    initial
    begin : receiver
        int seg_left;
        int mode;
        int run_left;
        seg_left  = 0;
        mode      = 0;
        run_left  = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                res_stall <= 1'b0;
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= 1'($urandom_range(0, 1));
                    default:
                        if (run_left > 0)
                        begin
                            run_left--;
                            res_stall <= 1'b1;
                        end
                        else
                        begin
                            res_stall <= 1'b0;
                            run_left = $urandom_range(1, 12);
                        end
                endcase
            end
        end
    end

    function automatic evt_t make_evt(input logic [OP_W-1:0] op, input logic syn,
                                      input logic ack, input logic fin);
        evt_t e;
        e.op       = op;
        e.syn_flag = syn;
        e.ack_flag = ack;
        e.fin_flag = fin;
        return e;
    endfunction

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic idle_sender(input int n);
        evt_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Offer one word and hold it until taken. Bursts of random length, with
    // a random gap (or none) between them; valid stays up inside a burst.
    task automatic put_word(input evt_t w);
        int gap;
        evt_valid <= 1'b1;
        evt_word  <= w;
        @(posedge clk);
        while (evt_stall)
            @(posedge clk);
        words_sent++;
        burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
                idle_sender(gap);
        end
    endtask

    // Pause the sender until every result word is back.
    task automatic drain_results();
        evt_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    // One word of a connection script, sometimes preceded by a noise word
    // (any op, undefined ones included, any flags).
    task automatic scripted(input logic [OP_W-1:0] op, input logic syn,
                            input logic ack, input logic fin);
        if ($urandom_range(0, 7) == 0)
            put_word(evt_t'($urandom_range(0, 63)));
        put_word(make_evt(op, syn, ack, fin));
    endtask

    // One random connection lifetime: an open, up to two sends, then a close; aborts close straight after the open.
    task automatic run_connection();
        int how;
        how = $urandom_range(0, 5);
        case (how)
            0:
            begin
                scripted(OP_ACTIVE_OPEN, coin(), coin(), coin());
                scripted(OP_PACKET, 1'b1, 1'b1, coin());
            end
            1:
            begin
                // simultaneous open: SYN alone, then ACK
                scripted(OP_ACTIVE_OPEN, coin(), coin(), coin());
                scripted(OP_PACKET, 1'b1, 1'b0, coin());
                scripted(OP_PACKET, coin(), 1'b1, coin());
            end
            2:
            begin
                scripted(OP_PASSIVE_OPEN, coin(), coin(), coin());
                scripted(OP_PACKET, 1'b1, coin(), coin());
                scripted(OP_PACKET, coin(), 1'b1, coin());
            end
            3:
            begin
                scripted(OP_PASSIVE_OPEN, coin(), coin(), coin());
                scripted(OP_SEND, coin(), coin(), coin());
                scripted(OP_PACKET, 1'b1, 1'b1, coin());
            end
            4:
            begin
                // abort from listen
                scripted(OP_PASSIVE_OPEN, coin(), coin(), coin());
                scripted(OP_CLOSE, coin(), coin(), coin());
                return;
            end
            default:
            begin
                // abort from syn_sent
                scripted(OP_ACTIVE_OPEN, coin(), coin(), coin());
                scripted(OP_CLOSE, coin(), coin(), coin());
                return;
            end
        endcase
        repeat ($urandom_range(0, 2))
            scripted(OP_SEND, coin(), coin(), coin());
        how = $urandom_range(0, 3);
        case (how)
            0:
            begin
                scripted(OP_CLOSE, coin(), coin(), coin());
                scripted(OP_PACKET, coin(), 1'b1, 1'b0);
                scripted(OP_PACKET, coin(), coin(), 1'b1);
            end
            1:
            begin
                scripted(OP_CLOSE, coin(), coin(), coin());
                scripted(OP_PACKET, coin(), 1'b0, 1'b1);
                scripted(OP_PACKET, coin(), 1'b1, coin());
            end
            2:
            begin
                scripted(OP_CLOSE, coin(), coin(), coin());
                scripted(OP_PACKET, coin(), 1'b1, 1'b1);
            end
            default:
            begin
                // passive close through close_wait and last_ack
                scripted(OP_PACKET, coin(), coin(), 1'b1);
                scripted(OP_CLOSE, coin(), coin(), coin());
                scripted(OP_PACKET, coin(), 1'b1, coin());
            end
        endcase
        if ($urandom_range(0, 39) == 0)
            drain_results();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        evt_valid <= 1'b0;
        evt_word  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through every state. Starts with a send in closed
        // (fault), an undefined op and a close in closed (both ignored, all
        // flags up so stray flags on non-packet ops are seen to do nothing).
        put_word(make_evt(OP_SEND, 1'b0, 1'b0, 1'b0));
        put_word(make_evt(3'd7, 1'b1, 1'b1, 1'b1));
        put_word(make_evt(OP_CLOSE, 1'b1, 1'b1, 1'b1));
        put_word(make_evt(OP_ACTIVE_OPEN, 1'b1, 1'b1, 1'b1));
        put_word(make_evt(OP_PACKET, 1'b1, 1'b1, 1'b0));  // -> established
        put_word(make_evt(OP_PACKET, 1'b0, 1'b0, 1'b1));  // -> close_wait
        put_word(make_evt(OP_SEND, 1'b0, 1'b0, 1'b0));    // fault
        put_word(make_evt(OP_CLOSE, 1'b0, 1'b0, 1'b0));   // -> last_ack
        put_word(make_evt(OP_PACKET, 1'b0, 1'b1, 1'b0));  // -> closed
        put_word(make_evt(OP_PASSIVE_OPEN, 1'b0, 1'b0, 1'b0));
        put_word(make_evt(OP_SEND, 1'b0, 1'b0, 1'b0));    // listen -> syn_sent
        put_word(make_evt(OP_PACKET, 1'b1, 1'b0, 1'b0));  // -> syn_rcvd
        put_word(make_evt(OP_CLOSE, 1'b0, 1'b0, 1'b0));   // -> fin_wait_1
        put_word(make_evt(OP_PACKET, 1'b0, 1'b1, 1'b1));  // through time_wait
        put_word(make_evt(OP_PASSIVE_OPEN, 1'b0, 1'b0, 1'b0));
        put_word(make_evt(OP_PACKET, 1'b1, 1'b0, 1'b0));
        put_word(make_evt(OP_PACKET, 1'b0, 1'b1, 1'b0));
        put_word(make_evt(OP_CLOSE, 1'b0, 1'b0, 1'b0));
        put_word(make_evt(OP_PACKET, 1'b0, 1'b1, 1'b0));  // -> fin_wait_2
        put_word(make_evt(OP_SEND, 1'b0, 1'b0, 1'b0));    // fault
        put_word(make_evt(OP_PACKET, 1'b0, 1'b0, 1'b1));  // through time_wait
        put_word(make_evt(OP_ACTIVE_OPEN, 1'b0, 1'b0, 1'b0));
        put_word(make_evt(OP_PACKET, 1'b1, 1'b0, 1'b0));  // -> syn_rcvd
        put_word(make_evt(OP_PACKET, 1'b0, 1'b1, 1'b0));
        put_word(make_evt(OP_CLOSE, 1'b0, 1'b0, 1'b0));
        put_word(make_evt(OP_PACKET, 1'b0, 1'b0, 1'b1));  // -> closing
        put_word(make_evt(OP_PACKET, 1'b0, 1'b1, 1'b0));  // through time_wait
        drain_results();

        // Random connection lifetimes with noise words mixed in.
        while (words_sent < RANDOM_WORDS + 27)
            run_connection();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && words_pending == 0)
            $display("tcp_connection_fsm_tb passed");
        else
            $display("tcp_connection_fsm_tb failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/tcf_pkg.sv
rtl/core/tcf_decode.sv
rtl/core/tcf_out_skid.sv
rtl/core/tcp_connection_fsm.sv
sim/tcp_connection_fsm_chk.sv
sim/tcp_connection_fsm_tb.sv
